// ===== rtl/gma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gma_pkg - shared types and constants for the grid mass assignment block
// Grid size, store geometry, register and action codes, queue entry layout.
// ----------------------------------------------------------------------------
package gma_pkg;

   // grid dimensions in cells
   localparam int GRID_X = 32;
   localparam int GRID_Y = 32;
   localparam int GRID_Z = 32;
   localparam int GRID_XY_MAX = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_MAX = (GRID_XY_MAX > GRID_Z) ? GRID_XY_MAX : GRID_Z;
   // width of a wrapped cell index along one axis
   localparam int AXIS_W = $clog2(GRID_MAX);

   // weight store
   localparam int ADDR_W      = 15;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int WEIGHT_W    = 40;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [WEIGHT_W-1:0] FILL_ONE   = WEIGHT_W'(65536);

   // fixed point widths
   localparam int POS_W  = 32;
   localparam int G_W    = 48;          // pos * scale >> 16
   localparam int BASE_W = 33;          // integer cell part, CIC may carry
   localparam int WT_W   = 17;          // Q16 weight, up to 1.0
   localparam logic [WT_W-1:0] ONE_W = WT_W'(65536);

   // residue unit: one byte of the base per step
   localparam int MOD_STEPS = (BASE_W + 7) / 8;
   localparam int SH_W      = MOD_STEPS * 8;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_SCHEME   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIODIC = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLAT_2D  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNIFORM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Z  = 3'd6;

   // kernels
   localparam logic [1:0] SCH_NGP = 2'd0;
   localparam logic [1:0] SCH_CIC = 2'd1;
   localparam logic [1:0] SCH_TSC = 2'd2;
   localparam logic [1:0] SCH_BAD = 2'd3;

   // request actions
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_DEPOSIT = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_DEPOSIT,
      OP_READ,
      OP_NOP
   } op_type;

   // per-axis list of cells, in deposit order
   typedef struct packed {
      logic [1:0]                  cnt;
      logic [2:0]                  ok;
      logic [2:0][AXIS_W-1:0]      idx;
      logic [2:0][WT_W-1:0]        w;
   } axis_type;

   typedef struct packed {
      op_type                      op;
      logic [ADDR_W-1:0]           cell_index;
      logic                        fill_one;
      axis_type                    x;
      axis_type                    y;
      axis_type                    z;
   } entry_type;

   // kernel spread of one coordinate before wrapping
   typedef struct packed {
      logic [BASE_W-1:0]           base;
      logic [2:0][WT_W-1:0]        w;
   } spread_type;

   typedef struct packed {
      logic                        init_busy;
   } status_type;

   function automatic int grid_dim(input int axis);
      int n;
      case (axis)
         0:       n = GRID_X;
         1:       n = GRID_Y;
         default: n = GRID_Z;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/grid_mass_assignment_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_mass_assignment_top - particle to grid mass assignment
// NGP, CIC or TSC deposit into a 3D store of Q24.16 cell weights, with
// clear and read actions.
//
//  channel  ports           direction  beat
//  req      req_valid/ready in         action, pos_x/y/z, cell_index
//  rsp      rsp_valid/ready out        cell_weight, dropped
//  csr      csr_wr_en       in         csr_index, csr_wdata, no wait
//
// Deposit: set-up in the front (scaling multiply, kernel weights,
// 5 byte steps of index wrapping, push), then a pop, a walk of one cell per
// cycle over 1, 8 or 27 cells (1, 4 or 9 in the 2D plane), a drain of the
// store pipe and the forming of the result beat.
// Clear: one store entry per cycle across the whole store, then the result beat.
// Read: a registered store read at cell_index, then the result beat.
// After reset the store is swept to zero; req_ready is low meanwhile.
// A two entry queue lets the front take new beats while the back works or
// the result beat stalls.
// ----------------------------------------------------------------------------
module grid_mass_assignment_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [gma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gma_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_x,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_y,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_z,
   input  wire logic [gma_pkg::ADDR_W-1:0]       req_cell_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [gma_pkg::WEIGHT_W-1:0]          rsp_cell_weight,
   output logic                                  rsp_dropped
);

   gma_pkg::status_type  status;
   gma_pkg::entry_type   push_entry;
   gma_pkg::entry_type   head;
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;

   // intake and set-up
   gma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_cell_index (req_cell_index),
      .status         (status),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // work queue
   gma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   // store engine and result beat
   gma_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head),
      .q_pop           (q_pop),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_weight (rsp_cell_weight),
      .rsp_dropped     (rsp_dropped)
   );

endmodule
`default_nettype wire

// ===== rtl/gma_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gma_ram - generic single write, single read RAM
// Registered read, old data returned on a same-address write.
// ----------------------------------------------------------------------------
module gma_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/gma_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gma_front - request intake, configuration and kernel set-up
// Holds the registers, scales positions, works out kernel weights and the
// wrapped cell indices, and pushes one work entry per beat into the queue.
// ----------------------------------------------------------------------------
module gma_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [gma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gma_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_x,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_y,
   input  wire logic [gma_pkg::POS_W-1:0]        req_pos_z,
   input  wire logic [gma_pkg::ADDR_W-1:0]       req_cell_index,
   input  wire gma_pkg::status_type              status,
   input  wire logic                             q_full,
   output logic                                  q_push,
   output gma_pkg::entry_type                    q_entry
);

   localparam int SH_W_L = gma_pkg::SH_W;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_MUL  = 5'b00010,
      F_WGT  = 5'b00100,
      F_MOD  = 5'b01000,
      F_PUSH = 5'b10000
   } fstate_type;

   // kernel weights and integer base for one scaled coordinate
   function automatic gma_pkg::spread_type axis_spread(
      input logic [gma_pkg::G_W-1:0] g,
      input logic [1:0]              scheme
   );
      gma_pkg::spread_type s;
      logic [gma_pkg::G_W:0]   u;
      logic signed [17:0]      d;
      logic signed [35:0]      dsq;
      logic [16:0]             lm;
      logic [16:0]             lp;
      logic [33:0]             sq_m;
      logic [33:0]             sq_p;
      logic [33:0]             wl;
      logic [33:0]             wc;
      logic [33:0]             wr;
      s    = '0;
      u    = {1'b0, g} + (gma_pkg::G_W+1)'(32768);
      d    = $signed({2'b00, g[15:0]}) - 18'sd32768;
      dsq  = d * d;
      lm   = 17'(18'sd32768 - d);
      lp   = 17'(18'sd32768 + d);
      sq_m = lm * lm;
      sq_p = lp * lp;
      wl   = sq_m >> 1;
      wc   = (34'd3 << 30) - dsq[33:0];
      wr   = sq_p >> 1;
      case (scheme)
         gma_pkg::SCH_NGP: begin
            s.base = {1'b0, g[gma_pkg::G_W-1:16]};
            s.w[0] = gma_pkg::ONE_W;
         end
         gma_pkg::SCH_CIC: begin
            // g - 0.5 held as g + 0.5 with the base one high
            s.base = u[gma_pkg::G_W:16];
            s.w[0] = gma_pkg::ONE_W - {1'b0, u[15:0]};
            s.w[1] = {1'b0, u[15:0]};
         end
         default: begin
            s.base = {1'b0, g[gma_pkg::G_W-1:16]};
            s.w[0] = gma_pkg::WT_W'((wl + 34'd32768) >> 16);
            s.w[1] = gma_pkg::WT_W'((wc + 34'd32768) >> 16);
            s.w[2] = gma_pkg::WT_W'((wr + 34'd32768) >> 16);
         end
      endcase
      return s;
   endfunction

   // one byte of long division by the grid size, remainder only
   function automatic logic [gma_pkg::AXIS_W-1:0] mod_step(
      input logic [gma_pkg::AXIS_W-1:0] r,
      input logic [7:0]                 digit,
      input int                         n
   );
      logic [15:0] v;
      v = (16'(r) << 8) | 16'(digit);
      for (int k = 7; k >= 0; k--) begin
         if (v >= (16'(n) << k)) begin
            v = v - (16'(n) << k);
         end
      end
      return v[gma_pkg::AXIS_W-1:0];
   endfunction

   // cell list for one axis from base, residue and weights
   function automatic gma_pkg::axis_type build_axis(
      input logic [gma_pkg::BASE_W-1:0]   base,
      input logic [gma_pkg::AXIS_W-1:0]   r,
      input logic [2:0][gma_pkg::WT_W-1:0] w,
      input int                           n,
      input logic [1:0]                   scheme,
      input logic                         periodic
   );
      gma_pkg::axis_type        a;
      logic [gma_pkg::AXIS_W-1:0] nm1;
      logic [gma_pkg::AXIS_W-1:0] rm;
      logic [gma_pkg::AXIS_W-1:0] rp;
      logic                     okm;
      logic                     ok0;
      logic                     okp;
      nm1 = gma_pkg::AXIS_W'(n - 1);
      rm  = (r == '0) ? nm1 : r - 1'b1;
      rp  = (r == nm1) ? '0 : r + 1'b1;
      okm = periodic | ((base != '0) && (base <= gma_pkg::BASE_W'(n)));
      ok0 = periodic | (base < gma_pkg::BASE_W'(n));
      okp = periodic | (base < gma_pkg::BASE_W'(n - 1));
      a   = '0;
      a.w = w;
      case (scheme)
         gma_pkg::SCH_NGP: begin
            a.cnt = 2'd1;
            a.idx[0] = r;
            a.ok[0]  = ok0;
         end
         gma_pkg::SCH_CIC: begin
            a.cnt = 2'd2;
            a.idx[0] = rm;
            a.ok[0]  = okm;
            a.idx[1] = r;
            a.ok[1]  = ok0;
         end
         default: begin
            a.cnt = 2'd3;
            a.idx[0] = rm;
            a.ok[0]  = okm;
            a.idx[1] = r;
            a.ok[1]  = ok0;
            a.idx[2] = rp;
            a.ok[2]  = okp;
         end
      endcase
      return a;
   endfunction

   fstate_type                        state_ff;
   fstate_type                        state_in;

   // configuration registers
   logic [1:0]                        scheme_ff;
   logic                              periodic_ff;
   logic                              flat_ff;
   logic                              uniform_ff;
   logic [gma_pkg::POS_W-1:0]         scale_ff [3];

   // item registers
   gma_pkg::op_type                   op_ff;
   gma_pkg::op_type                   acc_op;
   logic [gma_pkg::ADDR_W-1:0]        cidx_ff;
   logic                              fill_ff;
   logic [gma_pkg::POS_W-1:0]         pos_ff [3];
   logic [gma_pkg::G_W-1:0]           g_ff [3];
   gma_pkg::spread_type               sp_ff [3];
   gma_pkg::spread_type               sp_new [3];
   logic [63:0]                       prod [3];
   logic [SH_W_L-1:0]                 sh_ff [3];
   logic [gma_pkg::AXIS_W-1:0]        r_ff [3];
   logic [gma_pkg::STEP_W-1:0]        step_ff;
   logic                              accept;

   assign req_ready = (state_ff == F_IDLE) && !status.init_busy;
   assign accept    = req_valid && req_ready;

   // classify the incoming beat
   always_comb begin
      case (req_action)
         gma_pkg::ACT_CLEAR:   acc_op = gma_pkg::OP_CLEAR;
         gma_pkg::ACT_DEPOSIT: acc_op = (uniform_ff || (scheme_ff == gma_pkg::SCH_BAD)) ?
                                        gma_pkg::OP_NOP : gma_pkg::OP_DEPOSIT;
         gma_pkg::ACT_READ:    acc_op = gma_pkg::OP_READ;
         default:              acc_op = gma_pkg::OP_NOP;
      endcase
   end

   // scaling products and kernel spreads, one per axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a]   = 64'(pos_ff[a]) * 64'(scale_ff[a]);
         sp_new[a] = axis_spread(g_ff[a], scheme_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (acc_op == gma_pkg::OP_DEPOSIT) ? F_MUL : F_PUSH;
            end
         end
         F_MUL:  state_in = F_WGT;
         F_WGT:  state_in = F_MOD;
         F_MOD: begin
            if (step_ff == gma_pkg::STEP_W'(gma_pkg::MOD_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         scheme_ff   <= gma_pkg::SCH_NGP;
         periodic_ff <= 1'b0;
         flat_ff     <= 1'b0;
         uniform_ff  <= 1'b0;
         scale_ff[0] <= 32'd65536;
         scale_ff[1] <= 32'd65536;
         scale_ff[2] <= 32'd65536;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               gma_pkg::REG_SCHEME:   scheme_ff   <= csr_wdata[1:0];
               gma_pkg::REG_PERIODIC: periodic_ff <= csr_wdata[0];
               gma_pkg::REG_FLAT_2D:  flat_ff     <= csr_wdata[0];
               gma_pkg::REG_UNIFORM:  uniform_ff  <= csr_wdata[0];
               gma_pkg::REG_SCALE_X:  scale_ff[0] <= csr_wdata;
               gma_pkg::REG_SCALE_Y:  scale_ff[1] <= csr_wdata;
               gma_pkg::REG_SCALE_Z:  scale_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= acc_op;
         cidx_ff   <= req_cell_index;
         fill_ff   <= uniform_ff;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      for (int a = 0; a < 3; a++) begin
         if (state_ff == F_MUL) begin
            g_ff[a] <= prod[a][63:16];
         end
         if (state_ff == F_WGT) begin
            sp_ff[a] <= sp_new[a];
            sh_ff[a] <= SH_W_L'(sp_new[a].base);
            r_ff[a]  <= '0;
         end
         if (state_ff == F_MOD) begin
            r_ff[a]  <= mod_step(r_ff[a], sh_ff[a][SH_W_L-1 -: 8], gma_pkg::grid_dim(a));
            sh_ff[a] <= sh_ff[a] << 8;
         end
      end
      if (state_ff == F_WGT) begin
         step_ff <= '0;
      end else if (state_ff == F_MOD) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   // queue entry
   always_comb begin
      q_entry            = '0;
      q_entry.op         = op_ff;
      q_entry.cell_index = cidx_ff;
      q_entry.fill_one   = fill_ff;
      q_entry.x = build_axis(sp_ff[0].base, r_ff[0], sp_ff[0].w, gma_pkg::GRID_X,
                             scheme_ff, periodic_ff);
      q_entry.y = build_axis(sp_ff[1].base, r_ff[1], sp_ff[1].w, gma_pkg::GRID_Y,
                             scheme_ff, periodic_ff);
      if (flat_ff) begin
         q_entry.z.cnt   = 2'd1;
         q_entry.z.ok    = 3'b001;
         q_entry.z.w[0]  = gma_pkg::ONE_W;
      end else begin
         q_entry.z = build_axis(sp_ff[2].base, r_ff[2], sp_ff[2].w, gma_pkg::GRID_Z,
                                scheme_ff, periodic_ff);
      end
   end

   assign q_push = (state_ff == F_PUSH) && !q_full;

endmodule
`default_nettype wire

// ===== rtl/gma_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gma_queue - short work queue between front and back
// Lets the front take the next beat while the back is still busy.
// ----------------------------------------------------------------------------
module gma_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire gma_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output gma_pkg::entry_type       head,
   output logic                     empty
);

   localparam int PTR_W = (gma_pkg::QUEUE_DEPTH > 1) ? $clog2(gma_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(gma_pkg::QUEUE_DEPTH + 1);

   gma_pkg::entry_type  slot_ff [gma_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   assign full  = (count_ff == CNT_W'(gma_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(gma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(gma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/gma_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gma_back - weight store and cell update engine
// Sweeps the store on clear, walks the cell list of a deposit through a
// three stage read-add-write pipe with forwarding, serves reads, and holds
// the result beat.
// ----------------------------------------------------------------------------
module gma_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire gma_pkg::entry_type            q_head,
   output logic                               q_pop,
   output gma_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gma_pkg::WEIGHT_W-1:0]       rsp_cell_weight,
   output logic                               rsp_dropped
);

   localparam int PROD_W = 3 * gma_pkg::WT_W;
   localparam int ADD_W  = PROD_W - 32;

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_CLEAR = 7'b0000010,
      B_RUN   = 7'b0000100,
      B_DRAIN = 7'b0001000,
      B_READ  = 7'b0010000,
      B_RWAIT = 7'b0100000,
      B_DONE  = 7'b1000000
   } bstate_type;

   bstate_type                        state_ff;
   gma_pkg::entry_type                cur_ff;
   logic [gma_pkg::ADDR_W-1:0]        clr_addr_ff;
   logic                              clr_fill_ff;
   logic                              clr_respond_ff;
   logic [1:0]                        ca_ff;
   logic [1:0]                        cb_ff;
   logic [1:0]                        cc_ff;
   logic                              drop_ff;
   logic [gma_pkg::WEIGHT_W-1:0]      res_weight_ff;
   logic                              res_drop_ff;
   logic                              rsp_valid_ff;
   logic [gma_pkg::WEIGHT_W-1:0]      rsp_weight_ff;
   logic                              rsp_drop_ff;

   // pipe stages
   logic                              s1_valid_ff;
   logic [gma_pkg::ADDR_W-1:0]        s1_addr_ff;
   logic [2*gma_pkg::WT_W-1:0]        s1_wxy_ff;
   logic [gma_pkg::WT_W-1:0]          s1_wz_ff;
   logic                              s2_valid_ff;
   logic [gma_pkg::ADDR_W-1:0]        s2_addr_ff;
   logic [gma_pkg::WEIGHT_W-1:0]      s2_data_ff;
   logic [PROD_W-1:0]                 s2_prod_ff;
   logic                              s3_valid_ff;
   logic [gma_pkg::ADDR_W-1:0]        s3_addr_ff;
   logic [gma_pkg::WEIGHT_W-1:0]      s3_data_ff;

   // cell selection
   logic [gma_pkg::AXIS_W-1:0]        ix;
   logic [gma_pkg::AXIS_W-1:0]        iy;
   logic [gma_pkg::AXIS_W-1:0]        iz;
   logic [gma_pkg::WT_W-1:0]          wx;
   logic [gma_pkg::WT_W-1:0]          wy;
   logic [gma_pkg::WT_W-1:0]          wz;
   logic                              cell_ok;
   logic                              last_x;
   logic                              last_y;
   logic                              last_z;
   logic [31:0]                       lin;
   logic [gma_pkg::ADDR_W-1:0]        cell_addr;
   logic [2*gma_pkg::WT_W-1:0]        wxy;
   logic [PROD_W-1:0]                 prod;
   logic [gma_pkg::WEIGHT_W-1:0]      fwd_data;
   logic [PROD_W-1:0]                 prod_r;
   logic [ADD_W-1:0]                  add;
   logic [gma_pkg::WEIGHT_W:0]        sum_wide;
   logic [gma_pkg::WEIGHT_W-1:0]      s2_sum;
   logic                              out_free;

   // store ports
   logic                              ram_wr_en;
   logic [gma_pkg::ADDR_W-1:0]        ram_wr_addr;
   logic [gma_pkg::WEIGHT_W-1:0]      ram_wr_data;
   logic [gma_pkg::ADDR_W-1:0]        ram_rd_addr;
   logic [gma_pkg::WEIGHT_W-1:0]      ram_rd_data;

   gma_ram #(
      .WIDTH (gma_pkg::WEIGHT_W),
      .DEPTH (gma_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // current cell of the x, y, z walk
   always_comb begin
      ix      = cur_ff.x.idx[ca_ff];
      iy      = cur_ff.y.idx[cb_ff];
      iz      = cur_ff.z.idx[cc_ff];
      wx      = cur_ff.x.w[ca_ff];
      wy      = cur_ff.y.w[cb_ff];
      wz      = cur_ff.z.w[cc_ff];
      cell_ok = cur_ff.x.ok[ca_ff] & cur_ff.y.ok[cb_ff] & cur_ff.z.ok[cc_ff];
      last_x  = (ca_ff == cur_ff.x.cnt - 2'd1);
      last_y  = (cb_ff == cur_ff.y.cnt - 2'd1);
      last_z  = (cc_ff == cur_ff.z.cnt - 2'd1);
      lin     = 32'(ix) + 32'(iy) * 32'(gma_pkg::GRID_X)
              + 32'(iz) * 32'(gma_pkg::GRID_X * gma_pkg::GRID_Y);
      cell_addr = lin[gma_pkg::ADDR_W-1:0];
      wxy     = wx * wy;
   end

   // stage 1: newest value of the cell, then full weight product
   always_comb begin
      if (s2_valid_ff && (s2_addr_ff == s1_addr_ff)) begin
         fwd_data = s2_sum;
      end else if (s3_valid_ff && (s3_addr_ff == s1_addr_ff)) begin
         fwd_data = s3_data_ff;
      end else begin
         fwd_data = ram_rd_data;
      end
      prod = s1_wxy_ff * s1_wz_ff;
   end

   // stage 2: round to Q16 and add with saturation
   always_comb begin
      prod_r   = s2_prod_ff + PROD_W'(64'h8000_0000);
      add      = prod_r[PROD_W-1:32];
      sum_wide = {1'b0, s2_data_ff} + (gma_pkg::WEIGHT_W+1)'(add);
      s2_sum   = sum_wide[gma_pkg::WEIGHT_W] ? gma_pkg::WEIGHT_MAX
                                             : sum_wide[gma_pkg::WEIGHT_W-1:0];
   end

   // store access
   always_comb begin
      ram_wr_en   = s2_valid_ff || (state_ff == B_CLEAR);
      ram_wr_addr = (state_ff == B_CLEAR) ? clr_addr_ff : s2_addr_ff;
      ram_wr_data = (state_ff == B_CLEAR) ?
                    (clr_fill_ff ? gma_pkg::FILL_ONE : '0) : s2_sum;
      ram_rd_addr = (state_ff == B_READ) ? cur_ff.cell_index : cell_addr;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign status.init_busy = (state_ff == B_CLEAR) && !clr_respond_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_CLEAR;
         clr_addr_ff    <= '0;
         clr_fill_ff    <= 1'b0;
         clr_respond_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == B_RUN) && cell_ok;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         // result beat: raised once formed, dropped on handshake
         if ((state_ff == B_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  case (q_head.op)
                     gma_pkg::OP_CLEAR: begin
                        clr_addr_ff    <= '0;
                        clr_fill_ff    <= q_head.fill_one;
                        clr_respond_ff <= 1'b1;
                        state_ff       <= B_CLEAR;
                     end
                     gma_pkg::OP_DEPOSIT: state_ff <= B_RUN;
                     gma_pkg::OP_READ:    state_ff <= B_READ;
                     default:             state_ff <= B_DONE;
                  endcase
               end
            end
            B_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == gma_pkg::ADDR_W'(gma_pkg::STORE_DEPTH - 1)) begin
                  state_ff <= clr_respond_ff ? B_DONE : B_IDLE;
               end
            end
            B_RUN: begin
               if (last_x && last_y && last_z) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               if (!s1_valid_ff && !s2_valid_ff) begin
                  state_ff <= B_DONE;
               end
            end
            B_READ:  state_ff <= B_RWAIT;
            B_RWAIT: state_ff <= B_DONE;
            B_DONE: begin
               if (out_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // payload: walk counters, result, pipe data
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff        <= q_head;
         ca_ff         <= '0;
         cb_ff         <= '0;
         cc_ff         <= '0;
         drop_ff       <= 1'b0;
         res_weight_ff <= '0;
         res_drop_ff   <= 1'b0;
      end
      if (state_ff == B_RUN) begin
         if (!cell_ok) begin
            drop_ff <= 1'b1;
         end
         // z innermost, then y, then x
         if (!last_z) begin
            cc_ff <= cc_ff + 1'b1;
         end else begin
            cc_ff <= '0;
            if (!last_y) begin
               cb_ff <= cb_ff + 1'b1;
            end else begin
               cb_ff <= '0;
               ca_ff <= ca_ff + 1'b1;
            end
         end
      end
      if (state_ff == B_DRAIN) begin
         res_drop_ff <= drop_ff;
      end
      if (state_ff == B_RWAIT) begin
         res_weight_ff <= ram_rd_data;
      end
      if ((state_ff == B_DONE) && out_free) begin
         rsp_weight_ff <= res_weight_ff;
         rsp_drop_ff   <= res_drop_ff;
      end
      s1_addr_ff <= cell_addr;
      s1_wxy_ff  <= wxy;
      s1_wz_ff   <= wz;
      s2_addr_ff <= s1_addr_ff;
      s2_data_ff <= fwd_data;
      s2_prod_ff <= prod;
      s3_addr_ff <= s2_addr_ff;
      s3_data_ff <= s2_sum;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_weight = rsp_weight_ff;
   assign rsp_dropped     = rsp_drop_ff;

`ifndef ASSERT_OFF
   // the clear sweep owns the write port alone
   a_clear_no_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !s2_valid_ff)
      else $error("deposit write during clear sweep");

   // results are only formed once the pipe has drained
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("result formed with updates in flight");

   // a cell update starts only from the walk
   a_update_from_run: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(state_ff == B_RUN))
      else $error("cell update outside the deposit walk");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the grid mass assignment block
// Drives clear, deposit and read beats under several kernel, wrap, plane and
// scale settings. A local model of the weight store predicts every response
// beat, and each beat is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gma_pkg::*;

   localparam logic [1:0] ACT_NONE  = 2'd3;
   localparam int         QUIET_MAX = 200000;

   typedef struct {
      logic [1:0]        action;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic [ADDR_W-1:0] cell_index;
   } req_beat_t;

   typedef struct {
      logic [WEIGHT_W-1:0] cell_weight;
      logic                dropped;
   } rsp_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = ACT_NONE;
   logic [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [ADDR_W-1:0] req_cell_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WEIGHT_W-1:0] rsp_cell_weight;
   logic rsp_dropped;

   grid_mass_assignment_top DUT (.*);

   always #5 clock = ~clock;

   // model state: weight store and shadow registers
   logic [WEIGHT_W-1:0] cell_mass [STORE_DEPTH];
   logic [1:0]  m_scheme = SCH_NGP;
   logic        m_periodic = 1'b0, m_flat = 1'b0, m_uniform = 1'b0;
   logic [31:0] m_scale_x = 32'd65536, m_scale_y = 32'd65536, m_scale_z = 32'd65536;

   req_beat_t pending_beats [$];
   rsp_beat_t expected_rsp [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0, n_checked = 0, n_dropped = 0, n_deposits = 0, n_reads = 0;
   logic req_took = 1'b0;
   int quiet_cycles = 0;

   // spread one coordinate over its kernel cells; returns the cell count
   function automatic int kernel_spread(input logic [31:0] pos, input logic [31:0] scale,
                                        output longint cpos[3], output longint wt[3]);
      longint g, u, i, d, lm, lp;
      g = longint'(({32'd0, pos} * {32'd0, scale}) >> 16);
      if (m_scheme == SCH_NGP) begin
         cpos[0] = g >>> 16;
         wt[0] = 65536;
         return 1;
      end
      if (m_scheme == SCH_CIC) begin
         u = g + 32768;
         i = (u >>> 16) - 1;
         cpos[0] = i;     wt[0] = 65536 - (u & 16'hFFFF);
         cpos[1] = i + 1; wt[1] = u & 16'hFFFF;
         return 2;
      end
      i = g >>> 16;
      d = (g & 16'hFFFF) - 32768;
      lm = 32768 - d;
      lp = 32768 + d;
      cpos[0] = i - 1; wt[0] = (((lm * lm) >>> 1) + 32768) >>> 16;
      cpos[1] = i;     wt[1] = (((64'd3 << 30) - d * d) + 32768) >>> 16;
      cpos[2] = i + 1; wt[2] = (((lp * lp) >>> 1) + 32768) >>> 16;
      return 3;
   endfunction

   // wrap or reject an axis index
   function automatic bit axis_place(input longint c, input longint n, output longint o);
      longint r;
      if (m_periodic) begin
         r = c % n;
         if (r < 0) r += n;
         o = r;
         return 1'b1;
      end
      o = c;
      return (c >= 0 && c < n);
   endfunction

   // apply one beat to the model store and give the response it should cause
   function automatic rsp_beat_t grid_predict(input req_beat_t b);
      rsp_beat_t r;
      longint cx[3], cy[3], cz[3], wx[3], wy[3], wz[3];
      longint ix, iy, iz;
      logic [63:0] lin, add, sum;
      int nx, ny, nz;
      bit okx, oky, okz;
      r.cell_weight = '0;
      r.dropped = 1'b0;
      case (b.action)
         ACT_CLEAR: foreach (cell_mass[k]) cell_mass[k] = m_uniform ? FILL_ONE : '0;
         ACT_READ:  r.cell_weight = cell_mass[b.cell_index];
         ACT_DEPOSIT: if (!m_uniform && m_scheme != SCH_BAD) begin
            nx = kernel_spread(b.pos_x, m_scale_x, cx, wx);
            ny = kernel_spread(b.pos_y, m_scale_y, cy, wy);
            if (m_flat) begin
               nz = 1; cz[0] = 0; wz[0] = 65536;
            end else begin
               nz = kernel_spread(b.pos_z, m_scale_z, cz, wz);
            end
            for (int a = 0; a < nx; a++)
               for (int q = 0; q < ny; q++)
                  for (int c = 0; c < nz; c++) begin
                     okx = axis_place(cx[a], GRID_X, ix);
                     oky = axis_place(cy[q], GRID_Y, iy);
                     okz = axis_place(cz[c], GRID_Z, iz);
                     if (!(okx && oky && okz)) begin
                        r.dropped = 1'b1;
                        continue;
                     end
                     lin = (ix + iy * GRID_X + iz * GRID_X * GRID_Y) & 64'h7FFF;
                     add = (wx[a] * wy[q] * wz[c] + (64'd1 << 31)) >> 32;
                     sum = {24'd0, cell_mass[lin[14:0]]} + add;
                     cell_mass[lin[14:0]] = (sum > {24'd0, WEIGHT_MAX}) ?
                                            WEIGHT_MAX : sum[WEIGHT_W-1:0];
                  end
         end
         default: ;
      endcase
      return r;
   endfunction

   initial foreach (cell_mass[k]) cell_mass[k] = '0;

   // request driver: inputs move on the falling edge
   always @(negedge clock) begin
      req_beat_t b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            b = pending_beats.pop_front();
            req_action <= b.action;
            req_pos_x <= b.pos_x;
            req_pos_y <= b.pos_y;
            req_pos_z <= b.pos_z;
            req_cell_index <= b.cell_index;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin
      rsp_beat_t e;
      req_beat_t b;
      req_took <= req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            n_checked++;
            if (rsp_dropped) n_dropped++;
            if (rsp_cell_weight !== e.cell_weight) begin
               $error("cell_weight expected %0h actual %0h", e.cell_weight, rsp_cell_weight);
               errors++;
            end
            if (rsp_dropped !== e.dropped) begin
               $error("dropped expected %0b actual %0b", e.dropped, rsp_dropped);
               errors++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         b.action = req_action;
         b.pos_x = req_pos_x;
         b.pos_y = req_pos_y;
         b.pos_z = req_pos_z;
         b.cell_index = req_cell_index;
         if (b.action == ACT_DEPOSIT) n_deposits++;
         if (b.action == ACT_READ) n_reads++;
         expected_rsp.push_back(grid_predict(b));
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_SCHEME:   m_scheme = val[1:0];
         REG_PERIODIC: m_periodic = val[0];
         REG_FLAT_2D:  m_flat = val[0];
         REG_UNIFORM:  m_uniform = val[0];
         REG_SCALE_X:  m_scale_x = val;
         REG_SCALE_Y:  m_scale_y = val;
         REG_SCALE_Z:  m_scale_z = val;
         default: ;
      endcase
   endtask

   task automatic set_mode(input logic [1:0] sch, input bit per, input bit flat, input bit uni);
      csr_write(REG_SCHEME, {30'd0, sch});
      csr_write(REG_PERIODIC, {31'd0, per});
      csr_write(REG_FLAT_2D, {31'd0, flat});
      csr_write(REG_UNIFORM, {31'd0, uni});
   endtask

   task automatic set_scales(input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz);
      csr_write(REG_SCALE_X, sx);
      csr_write(REG_SCALE_Y, sy);
      csr_write(REG_SCALE_Z, sz);
   endtask

   task automatic push_beat(input logic [1:0] act, input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [ADDR_W-1:0] idx);
      req_beat_t b;
      b.action = act; b.pos_x = px; b.pos_y = py; b.pos_z = pz; b.cell_index = idx;
      pending_beats.push_back(b);
   endtask

   // hold off until the block has nothing in flight
   task automatic drain;
      while (pending_beats.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // positions mostly in a small corner so reads find weight, some anywhere
   function automatic logic [31:0] rand_pos();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return $urandom_range(0, 6 << 16);
      if (sel < 9) return $urandom_range(0, 34 << 16);
      return $urandom;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_index();
      if ($urandom_range(0, 9) < 7)
         return ADDR_W'($urandom_range(0, 7) + $urandom_range(0, 7) * GRID_X +
                        $urandom_range(0, 7) * GRID_X * GRID_Y);
      return ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 4))
         0: return 32'd65536;
         1: return 32'd32768;
         2: return 32'd131072;
         3: return $urandom_range(16384, 262144);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [1:0] act;
      int sel;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default NGP, edges of the grid and of each field
      send_idle_pct = 8; recv_idle_pct = 75;
      push_beat(ACT_READ, '0, '0, '0, '0);
      push_beat(ACT_DEPOSIT, 32'h0000_8000, '0, '0, '0);
      push_beat(ACT_READ, '0, '0, '0, '0);
      push_beat(ACT_DEPOSIT, 32'h001F_FFFF, 32'h001F_0000, 32'h001F_0000, '0);
      push_beat(ACT_READ, '0, '0, '0, ADDR_W'(STORE_DEPTH - 1));
      push_beat(ACT_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);  // outside
      push_beat(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      push_beat(ACT_READ, '0, '0, '0, '1);
      drain();
      // CIC and TSC with wrap across the low edge
      set_mode(SCH_CIC, 1'b1, 1'b0, 1'b0);
      push_beat(ACT_DEPOSIT, '0, '0, '0, '0);
      push_beat(ACT_READ, '0, '0, '0, ADDR_W'(GRID_X - 1));
      drain();
      csr_write(REG_SCHEME, {30'd0, SCH_TSC});
      push_beat(ACT_DEPOSIT, 32'h0000_8000, 32'h001F_C000, 32'h0000_4000, '0);
      push_beat(ACT_READ, '0, '0, '0, '0);
      drain();
      // TSC without wrap drops the low neighbour; 2D plane; extreme scales
      set_mode(SCH_TSC, 1'b0, 1'b1, 1'b0);
      set_scales(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      push_beat(ACT_DEPOSIT, 32'h0000_0001, 32'h1234_5678, 32'hFFFF_FFFF, '0);
      push_beat(ACT_DEPOSIT, '0, '0, '0, '0);
      push_beat(ACT_READ, '0, '0, '0, '0);
      drain();
      // unknown kernel leaves the store alone
      set_mode(SCH_BAD, 1'b0, 1'b0, 1'b0);
      set_scales(32'd65536, 32'd65536, 32'd65536);
      push_beat(ACT_DEPOSIT, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, '0);
      push_beat(ACT_READ, '0, '0, '0, ADDR_W'(2 + 2 * GRID_X + 2 * GRID_X * GRID_Y));
      drain();
      // uniform fill: clear writes one, deposits ignored
      set_mode(SCH_NGP, 1'b0, 1'b0, 1'b1);
      push_beat(ACT_CLEAR, '0, '0, '0, '0);
      push_beat(ACT_DEPOSIT, '0, '0, '0, '0);
      push_beat(ACT_READ, '0, '0, '0, '0);
      push_beat(ACT_READ, '0, '0, '0, '1);
      drain();

      // random phases under a spread of settings
      for (int p = 0; p < 12; p++) begin
         if (p < 4) begin
            send_idle_pct = 8; recv_idle_pct = 75;
         end else if (p < 8) begin
            send_idle_pct = 75; recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         set_mode(2'(p % 3), 1'((p / 3) % 2), 1'((p / 6) % 2), 1'(p == 11));
         set_scales(rand_scale(), rand_scale(), rand_scale());
         if (p % 2 == 0 || p == 11)
            push_beat(ACT_CLEAR, $urandom, $urandom, $urandom, ADDR_W'($urandom));
         for (int n = 0; n < 100; n++) begin
            sel = $urandom_range(0, 99);
            act = (sel < 60) ? ACT_DEPOSIT : (sel < 96) ? ACT_READ : ACT_NONE;
            push_beat(act, rand_pos(), rand_pos(), rand_pos(), rand_index());
         end
         drain();
      end

      $display("Checked %0d response beats: %0d deposits (%0d dropped), %0d reads,",
               n_checked, n_deposits, n_dropped, n_reads);
      $display("over NGP/CIC/TSC, wrap and drop, 2D plane, uniform fill and extreme scales.");
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/gma_pkg.sv
rtl/gma_ram.sv
rtl/gma_front.sv
rtl/gma_queue.sv
rtl/gma_back.sv
rtl/grid_mass_assignment_top.sv
tb/sv/tb_top.sv
